// ----- design/etd_pkg.sv -----
// ----------------------------------------------------------------------------
// etd_pkg
// Shared types and constants for the envelope tap detector.
// ----------------------------------------------------------------------------
`default_nettype none
package etd_pkg;

  typedef enum logic [1:0] {
    PHASE_IDLE    = 2'd0,
    PHASE_EVENT   = 2'd1,
    PHASE_LOCKOUT = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WINDOW,
    ST_BLOCK,
    ST_SCAN,
    ST_SLEW,
    ST_LEVELS,
    ST_EVENT,
    ST_OUT
  } state_t;

  localparam logic [2:0] REG_QUIET  = 3'd0;
  localparam logic [2:0] REG_STEP   = 3'd1;
  localparam logic [2:0] REG_LOWOFS = 3'd2;
  localparam logic [2:0] REG_BAND   = 3'd3;
  localparam logic [2:0] REG_MINLOW = 3'd4;
  localparam logic [2:0] REG_MAXCEL = 3'd5;
  localparam logic [2:0] REG_MINDUR = 3'd6;
  localparam logic [2:0] REG_MAXDUR = 3'd7;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture sample into window
    logic win_step;  // compare one window slot
    logic block;     // update block tracker
    logic scan_init; // start history scan
    logic scan_step; // compare one history slot
    logic slew;      // move baseline toward floor
    logic levels;    // recompute thresholds
    logic evt;       // run event logic
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic win_done;
    logic need_scan;   // end of block with history present
    logic need_levels; // first sample before any quiet block
    logic scan_done;
  } stat_t;

endpackage
`default_nettype wire

// ----- design/etd_ctrl.sv -----
// ----------------------------------------------------------------------------
// etd_ctrl
// Sequencer: steps one sample through window and block, then scan and slew and levels as needed, then event and output.
// ----------------------------------------------------------------------------
`default_nettype none
module etd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire etd_pkg::stat_t stat,
  output etd_pkg::cmd_t       cmd
);

  etd_pkg::state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      etd_pkg::ST_IDLE:   if (in_valid) state_nxt = etd_pkg::ST_WINDOW;
      etd_pkg::ST_WINDOW: if (stat.win_done) state_nxt = etd_pkg::ST_BLOCK;
      etd_pkg::ST_BLOCK: begin
        if (stat.need_scan) state_nxt = etd_pkg::ST_SCAN;
        else if (stat.need_levels) state_nxt = etd_pkg::ST_LEVELS;
        else state_nxt = etd_pkg::ST_EVENT;
      end
      etd_pkg::ST_SCAN:   if (stat.scan_done) state_nxt = etd_pkg::ST_SLEW;
      etd_pkg::ST_SLEW:   state_nxt = etd_pkg::ST_LEVELS;
      etd_pkg::ST_LEVELS: state_nxt = etd_pkg::ST_EVENT;
      etd_pkg::ST_EVENT:  state_nxt = etd_pkg::ST_OUT;
      etd_pkg::ST_OUT: begin
        if (out_ready) state_nxt = etd_pkg::ST_IDLE;
      end
      default: state_nxt = etd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      etd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      etd_pkg::ST_WINDOW: cmd.win_step = 1'b1;
      etd_pkg::ST_BLOCK: begin
        cmd.block     = 1'b1;
        cmd.scan_init = stat.need_scan;
      end
      etd_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
      etd_pkg::ST_SLEW:   cmd.slew = 1'b1;
      etd_pkg::ST_LEVELS: cmd.levels = 1'b1;
      etd_pkg::ST_EVENT:  cmd.evt = 1'b1;
      etd_pkg::ST_OUT:    out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= etd_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ----- design/etd_dp.sv -----
// ----------------------------------------------------------------------------
// etd_dp
// Datapath: window, block tracker, floor history, levels and event state.
// ----------------------------------------------------------------------------
`default_nettype none
module etd_dp #(
  parameter int WINDOW_DEPTH    = 4,
  parameter int BLOCK_SAMPLES   = 20,
  parameter int HISTORY_BLOCKS  = 10,
  parameter int BRIDGE_SAMPLES  = 10,
  parameter int LOCKOUT_SAMPLES = 30
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire etd_pkg::cmd_t      cmd,
  output etd_pkg::stat_t          stat,
  input  wire logic signed [15:0] in_sample,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [31:0]        cfg_data,
  output logic [15:0]             activity,
  output logic                    tap,
  output logic [7:0]              tap_length,
  output logic [15:0]             peak_activity,
  output logic [31:0]             tap_total,
  output logic [15:0]             baseline_level,
  output logic [17:0]             lower_level,
  output logic [17:0]             upper_level,
  output logic [1:0]              phase
);

  localparam int WW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int WF = $clog2(WINDOW_DEPTH + 1);
  localparam int BW = $clog2(BLOCK_SAMPLES + 1);
  localparam int HW = (HISTORY_BLOCKS > 1) ? $clog2(HISTORY_BLOCKS) : 1;
  localparam int HF = $clog2(HISTORY_BLOCKS + 1);
  localparam int QW = $clog2(BRIDGE_SAMPLES + 1);
  localparam int LW = $clog2(LOCKOUT_SAMPLES + 1);

  // configuration
  logic [15:0] quiet_r, step_r, lowofs_r, band_r, minlow_r;
  logic [16:0] maxcel_r;
  logic [7:0]  mindur_r, maxdur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_r  <= 16'd1500;
      step_r   <= 16'd175;
      lowofs_r <= 16'd2200;
      band_r   <= 16'd3000;
      minlow_r <= 16'd2500;
      maxcel_r <= 17'd25000;
      mindur_r <= 8'd5;
      maxdur_r <= 8'd60;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        etd_pkg::REG_QUIET:  quiet_r  <= cfg_data[15:0];
        etd_pkg::REG_STEP:   step_r   <= cfg_data[15:0];
        etd_pkg::REG_LOWOFS: lowofs_r <= cfg_data[15:0];
        etd_pkg::REG_BAND:   band_r   <= cfg_data[15:0];
        etd_pkg::REG_MINLOW: minlow_r <= cfg_data[15:0];
        etd_pkg::REG_MAXCEL: maxcel_r <= cfg_data[16:0];
        etd_pkg::REG_MINDUR: mindur_r <= cfg_data[7:0];
        etd_pkg::REG_MAXDUR: maxdur_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sample window, scanned one slot per cycle
  logic signed [15:0] win_r [WINDOW_DEPTH];
  logic [WW-1:0] whead_r, wi_r;
  logic [WF-1:0] wfill_r;
  logic signed [15:0] wmin_r, wmax_r;
  logic [15:0] act_r;
  logic [WF-1:0] wfill_nxt;
  logic [15:0] spread;

  assign wfill_nxt = (wfill_r < WF'(WINDOW_DEPTH)) ? wfill_r + 1'b1 : wfill_r;
  assign stat.win_done = ({1'b0, wi_r} + 1'b1 >= (WW+1)'(wfill_r)) ||
                         (32'(wi_r) == WINDOW_DEPTH - 1);
  assign spread = 16'(wmax_r - wmin_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whead_r <= '0;
      wfill_r <= '0;
    end else if (cmd.load) begin
      whead_r <= (32'(whead_r) == WINDOW_DEPTH - 1) ? '0 : whead_r + 1'b1;
      wfill_r <= wfill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win_r[whead_r] <= in_sample;
      wi_r   <= '0;
      // slot 0 seeds the scan; it may be the new sample
      wmin_r <= (whead_r == '0) ? in_sample : win_r[0];
      wmax_r <= (whead_r == '0) ? in_sample : win_r[0];
    end else if (cmd.win_step) begin
      if (!stat.win_done) begin
        wi_r <= wi_r + 1'b1;
        if (win_r[wi_r + 1'b1] < wmin_r) wmin_r <= win_r[wi_r + 1'b1];
        if (win_r[wi_r + 1'b1] > wmax_r) wmax_r <= win_r[wi_r + 1'b1];
      end else begin
        act_r <= spread;
      end
    end
  end

  // block tracker and history ring
  logic [BW-1:0] bpos_r;
  logic [15:0]   blow_r, bhigh_r, blow_n, bhigh_n;
  logic [15:0]   hist_r [HISTORY_BLOCKS];
  logic [HW-1:0] hhead_r, hi_r;
  logic [HF-1:0] hfill_r, hfill_n;
  logic          eob, quiet;
  logic [15:0]   m1_r, m2_r, fl;
  logic [15:0]   base_r;
  logic [17:0]   lower_r, upper_r;

  assign blow_n  = (bpos_r == '0 || act_r < blow_r) ? act_r : blow_r;
  assign bhigh_n = (bpos_r == '0 || act_r > bhigh_r) ? act_r : bhigh_r;
  assign eob     = (32'(bpos_r) + 1 >= BLOCK_SAMPLES);
  assign quiet   = (bhigh_n - blow_n) <= quiet_r;
  assign hfill_n = (eob && quiet && hfill_r < HF'(HISTORY_BLOCKS)) ? hfill_r + 1'b1
                                                                  : hfill_r;
  assign stat.need_scan   = eob && (hfill_n != '0);
  assign stat.need_levels = !eob && (hfill_r == '0) && (bpos_r == '0);
  assign stat.scan_done   = ({1'b0, hi_r} + 1'b1 >= (HW+1)'(hfill_r));
  assign fl = (hfill_r > HF'(1)) ? m2_r : m1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpos_r  <= '0;
      blow_r  <= '0;
      bhigh_r <= '0;
      hhead_r <= '0;
      hfill_r <= '0;
    end else if (cmd.block) begin
      blow_r  <= blow_n;
      bhigh_r <= bhigh_n;
      bpos_r  <= eob ? '0 : bpos_r + 1'b1;
      hfill_r <= hfill_n;
      if (eob && quiet)
        hhead_r <= (32'(hhead_r) == HISTORY_BLOCKS - 1) ? '0 : hhead_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.block && eob && quiet) hist_r[hhead_r] <= blow_n;
    // two-smallest scan, one entry per cycle
    if (cmd.scan_init) begin
      hi_r <= '0;
      m1_r <= 16'hFFFF;
      m2_r <= 16'hFFFF;
    end else if (cmd.scan_step) begin
      if (!stat.scan_done) hi_r <= hi_r + 1'b1;
      if (hist_r[hi_r] < m1_r) begin
        m2_r <= m1_r;
        m1_r <= hist_r[hi_r];
      end else if (hist_r[hi_r] < m2_r) begin
        m2_r <= hist_r[hi_r];
      end
    end
  end

  // baseline slew and thresholds
  logic [15:0] diff, stepd;
  logic [22:0] prod_r;
  logic [17:0] lo_raw, lo_cl;
  logic [18:0] hi_raw;
  logic [15:0] pct;

  assign diff  = (fl > base_r) ? fl - base_r : base_r - fl;
  assign stepd = (diff > step_r) ? step_r : diff;
  // 28*b/100 == (28*b*5243)>>19 is exact only for small b; use 7*b/25 via
  // reciprocal 2^24/25 rounded up, exact for numerators up to 7*65535
  logic [43:0] recip;
  assign recip  = 44'(prod_r) * 44'd671089;
  assign pct    = recip[39:24];
  assign lo_raw = 18'(base_r) + 18'(lowofs_r) + 18'(pct);
  assign lo_cl  = (lo_raw < 18'(minlow_r)) ? 18'(minlow_r) : lo_raw;
  assign hi_raw = 19'(lo_cl) + 19'(band_r) + 19'(base_r[15:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      lower_r <= '0;
      upper_r <= '0;
      prod_r  <= '0;
    end else begin
      if (cmd.block && stat.need_levels) begin
        base_r <= act_r;
        prod_r <= 23'(act_r) * 23'd7;
      end else if (cmd.slew) begin
        base_r <= (fl > base_r) ? base_r + stepd : base_r - stepd;
        prod_r <= 23'((fl > base_r) ? base_r + stepd : base_r - stepd) * 23'd7;
      end
      if (cmd.levels) begin
        lower_r <= lo_cl;
        upper_r <= (hi_raw > 19'(maxcel_r)) ? 18'(maxcel_r) : 18'(hi_raw);
      end
    end
  end

  // event logic
  logic        open_r, good_r, tap_r;
  logic [7:0]  age_r, alen_r, last_r, age_n;
  logic [15:0] peak_r;
  logic [QW-1:0] qrun_r;
  logic [LW-1:0] lock_r;
  logic [31:0] cnt_r;
  etd_pkg::phase_t phase_r;
  logic        above;

  assign above = 18'(act_r) > lower_r;
  assign age_n = (age_r < 8'd255) ? age_r + 1'b1 : age_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      good_r  <= 1'b0;
      tap_r   <= 1'b0;
      age_r   <= '0;
      alen_r  <= '0;
      last_r  <= '0;
      peak_r  <= '0;
      qrun_r  <= '0;
      lock_r  <= '0;
      cnt_r   <= '0;
      phase_r <= etd_pkg::PHASE_IDLE;
    end else if (cmd.evt) begin
      tap_r <= 1'b0;
      if (lock_r != '0) begin
        lock_r <= lock_r - 1'b1;
        if (lock_r == LW'(1)) phase_r <= etd_pkg::PHASE_IDLE;
      end else if (!open_r) begin
        if (above) begin
          open_r  <= 1'b1;
          good_r  <= 18'(act_r) <= upper_r;
          age_r   <= '0;
          alen_r  <= 8'd1;
          peak_r  <= act_r;
          qrun_r  <= '0;
          phase_r <= etd_pkg::PHASE_EVENT;
        end
      end else begin
        if (act_r > peak_r) peak_r <= act_r;
        age_r <= age_n;
        if (18'(act_r) > upper_r || age_n > maxdur_r) good_r <= 1'b0;
        if (above) begin
          qrun_r <= '0;
          alen_r <= (age_n < 8'd255) ? age_n + 1'b1 : 8'd255;
        end else if (32'(qrun_r) + 1 >= BRIDGE_SAMPLES) begin
          if (good_r && !(18'(act_r) > upper_r || age_n > maxdur_r) &&
              alen_r >= mindur_r && alen_r <= maxdur_r) begin
            cnt_r   <= cnt_r + 1'b1;
            last_r  <= alen_r;
            tap_r   <= 1'b1;
            lock_r  <= LW'(LOCKOUT_SAMPLES);
            phase_r <= etd_pkg::PHASE_LOCKOUT;
          end else begin
            phase_r <= etd_pkg::PHASE_IDLE;
          end
          open_r <= 1'b0;
          qrun_r <= '0;
        end else begin
          qrun_r <= qrun_r + 1'b1;
        end
      end
    end
  end

  assign activity       = act_r;
  assign tap            = tap_r;
  assign tap_length     = last_r;
  assign peak_activity  = peak_r;
  assign tap_total      = cnt_r;
  assign baseline_level = base_r;
  assign lower_level    = lower_r;
  assign upper_level    = upper_r;
  assign phase          = phase_r;

endmodule
`default_nettype wire

// ----- design/envelope_tap_detector_core.sv -----
// ----------------------------------------------------------------------------
// envelope_tap_detector_core
// Tap detector on the peak-to-peak envelope of a signed sample stream.
// ----------------------------------------------------------------------------
// One sample is taken at a time and gives one result. Each sample passes
// through the window scan, the block update and the event logic. The first
// sample of a block before any quiet block adds a threshold recompute. The
// end of a block with stored history adds a scan of each stored entry (up
// to HISTORY_BLOCKS), a baseline slew and a threshold recompute. The window
// scan covers only the filled slots while the window is still filling. The
// window scan and history scan take one slot per cycle. The result waits in
// the output register until taken; the next sample is accepted in the cycle
// after that transfer.
`default_nettype none
module envelope_tap_detector_core #(
  parameter int WINDOW_DEPTH    = 4,
  parameter int BLOCK_SAMPLES   = 20,
  parameter int HISTORY_BLOCKS  = 10,
  parameter int BRIDGE_SAMPLES  = 10,
  parameter int LOCKOUT_SAMPLES = 30
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_activity,
  output logic                    out_tap,
  output logic [7:0]              out_tap_length,
  output logic [15:0]             out_peak_activity,
  output logic [31:0]             out_tap_total,
  output logic [15:0]             out_baseline_level,
  output logic [17:0]             out_lower_level,
  output logic [17:0]             out_upper_level,
  output logic [1:0]              out_phase,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  etd_pkg::cmd_t  cmd;
  etd_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  etd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd
  );

  etd_dp #(
    .WINDOW_DEPTH(WINDOW_DEPTH), .BLOCK_SAMPLES(BLOCK_SAMPLES),
    .HISTORY_BLOCKS(HISTORY_BLOCKS), .BRIDGE_SAMPLES(BRIDGE_SAMPLES),
    .LOCKOUT_SAMPLES(LOCKOUT_SAMPLES)
  ) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_sample,
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
    .activity(out_activity), .tap(out_tap), .tap_length(out_tap_length),
    .peak_activity(out_peak_activity), .tap_total(out_tap_total),
    .baseline_level(out_baseline_level), .lower_level(out_lower_level),
    .upper_level(out_upper_level), .phase(out_phase)
  );

  // a tap only appears in lockout phase
  a_tap_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tap |-> out_phase == etd_pkg::PHASE_LOCKOUT)
    else $error("tap outside lockout");

  // no new sample while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready with result pending");

  // tap count advances only with a reported tap
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && $past(out_tap_total) != out_tap_total |-> out_tap)
    else $error("tap count moved without tap");

endmodule
`default_nettype wire
